// ===== hdl/dqd_pkg.sv =====
// Package for the debounced quadrature decoder: payload structs, register
// indexes, reset values and step codes. No dependencies.
`timescale 1ns / 1ps

package dqd_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int WINLEN_W  = 6;
  localparam int SPC_W     = 3;
  localparam int POS_W     = 16;
  localparam int STEP_W    = 2;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = 6;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PULLUP_A        = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PULLUP_B        = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEPS_PER_CLICK = 2'd3;

  // Reset values
  localparam logic [WINLEN_W-1:0] WINDOW_LENGTH_RST   = 6'd8;
  localparam logic                PULLUP_A_RST        = 1'b1;
  localparam logic                PULLUP_B_RST        = 1'b1;
  localparam logic [SPC_W-1:0]    STEPS_PER_CLICK_RST = 3'd4;

  // Both edges of A are counted at this setting
  localparam logic [SPC_W-1:0] STEPS_X2 = 3'd2;

  localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sd0;
  localparam logic signed [STEP_W-1:0] STEP_CW   = 2'sd1;
  localparam logic signed [STEP_W-1:0] STEP_CCW  = -2'sd1;

  typedef struct packed {
    logic raw_a;
    logic raw_b;
  } dqd_in_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step;
    logic signed [POS_W-1:0]  position;
    logic                     closed_a;
    logic                     closed_b;
  } dqd_out_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     wdata;
  } dqd_cfg_t;

endpackage

// ===== hdl/dqd_stream_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
// Payload types come from dqd_pkg.
`timescale 1ns / 1ps

interface dqd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/dqd_debounce.sv =====
// One pin of the decoder: sliding sample window and debounced level.
// Uses dqd_pkg for widths.
`timescale 1ns / 1ps

module dqd_debounce
  import dqd_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_en,
  input  logic                raw,
  input  logic                invert,
  input  logic [WINLEN_W-1:0] window_length,
  output logic                level,
  output logic                level_next
);

  logic [MAX_WINDOW-1:0] window;
  logic [MAX_WINDOW-1:0] window_next;
  logic [MAX_WINDOW-1:0] mask;
  logic                  all_zero;
  logic                  all_one;

  // Length 0 acts as 1; lengths past the window act as the full window.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_mask
    assign mask[i] = (i == 0) ? 1'b1 : (WINLEN_W'(i) < window_length);
  end

  assign window_next = MAX_WINDOW'({window, raw});
  assign all_zero    = ((window_next & mask) == '0);
  assign all_one     = ((window_next | ~mask) == '1);

  always_comb begin
    if (all_zero) begin
      level_next = invert;
    end else if (all_one) begin
      level_next = ~invert;
    end else begin
      level_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      level  <= 1'b0;
    end else if (sample_en) begin
      window <= window_next;
      level  <= level_next;
    end
  end

endmodule

// ===== hdl/dqd_out_buffer.sv =====
// Two-entry result buffer: output register plus skid register, so an item
// can be taken while a result is held. Uses dqd_pkg for the result type.
`timescale 1ns / 1ps

module dqd_out_buffer
  import dqd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  dqd_out_t in_data,
  output logic     in_ready,
  output logic     out_valid,
  output dqd_out_t out_data,
  input  logic     out_ready
);

  logic     skid_valid;
  dqd_out_t skid_data;
  logic     in_take;
  logic     out_take;

  assign in_ready = ~skid_valid;
  assign in_take  = in_valid & in_ready;
  assign out_take = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (out_valid & ~out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (in_take) begin
      if (out_valid & ~out_take) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    in_take && out_valid && !out_ready |=> skid_valid)
    else $error("item taken during stall was not parked");

endmodule

// ===== hdl/debounced_quadrature_decoder.sv =====
// Debounced quadrature decoder top level: debounce of pins A and B, edge
// detection on A and wrapping position count. Uses dqd_pkg, dqd_stream_if,
// dqd_debounce and dqd_out_buffer.
//
// Use:
//   samples : one item per raw sample of pins A and B.
//   results : one item per sample: step (+1, -1, 0), position, and the
//             debounced, polarity-corrected levels closed_a and closed_b.
//   cfg     : register writes (window_length, pullup_a, pullup_b,
//             steps_per_click), always ready; write only while idle.
// Results are registered in the output register, or in the skid register.
// Throughput: one item per cycle while samples.ready is high; window compare,
//   edge detect and the count add sit between pin and result registers.
// Stall: a two-entry result buffer keeps one more item coming in while a
//   result waits; samples.ready drops once both entries are full.
// Reset: windows cleared to zeros, levels open, count zero, registers at
//   8, 1, 1, 4; no results pending.
`timescale 1ns / 1ps

module debounced_quadrature_decoder
  import dqd_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  dqd_stream_if.sink   samples,
  dqd_stream_if.source results,
  dqd_stream_if.sink   cfg
);

  logic [WINLEN_W-1:0] window_length;
  logic                pullup_a;
  logic                pullup_b;
  logic [SPC_W-1:0]    steps_per_click;

  logic                   accept;
  logic                   level_a;
  logic                   level_a_next;
  logic                   level_b;
  logic                   level_b_next;
  logic                   buf_ready;
  logic signed [STEP_W-1:0] step_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH+POS_W-1:0] count_ext;
  dqd_out_t               result_next;
  dqd_in_t                sample;
  dqd_cfg_t               cfg_item;

  assign sample   = samples.data;
  assign cfg_item = cfg.data;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= WINDOW_LENGTH_RST;
      pullup_a        <= PULLUP_A_RST;
      pullup_b        <= PULLUP_B_RST;
      steps_per_click <= STEPS_PER_CLICK_RST;
    end else if (cfg.valid) begin
      unique case (cfg_item.index)
        REG_WINDOW_LENGTH:   window_length   <= cfg_item.wdata;
        REG_PULLUP_A:        pullup_a        <= cfg_item.wdata[0];
        REG_PULLUP_B:        pullup_b        <= cfg_item.wdata[0];
        REG_STEPS_PER_CLICK: steps_per_click <= cfg_item.wdata[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  assign samples.ready = buf_ready;
  assign accept        = samples.valid & buf_ready;

  dqd_debounce #(.MAX_WINDOW(MAX_WINDOW)) u_pin_a (
    .clk           (clk),
    .rst           (rst),
    .sample_en     (accept),
    .raw           (sample.raw_a),
    .invert        (pullup_a),
    .window_length (window_length),
    .level         (level_a),
    .level_next    (level_a_next)
  );

  dqd_debounce #(.MAX_WINDOW(MAX_WINDOW)) u_pin_b (
    .clk           (clk),
    .rst           (rst),
    .sample_en     (accept),
    .raw           (sample.raw_b),
    .invert        (pullup_b),
    .window_length (window_length),
    .level         (level_b),
    .level_next    (level_b_next)
  );

  // Edge on A, direction from the updated B level
  always_comb begin
    if (!level_a && level_a_next) begin
      step_next = level_b_next ? STEP_CW : STEP_CCW;
    end else if (steps_per_click == STEPS_X2 && level_a && !level_a_next) begin
      step_next = level_b_next ? STEP_CCW : STEP_CW;
    end else begin
      step_next = STEP_NONE;
    end
  end

  assign count_next = count + {{(COUNT_WIDTH-STEP_W){step_next[STEP_W-1]}}, step_next};
  assign count_ext  = {{POS_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_comb begin
    result_next.step     = step_next;
    result_next.position = count_ext[POS_W-1:0];
    result_next.closed_a = level_a_next;
    result_next.closed_b = level_b_next;
  end

  dqd_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_data   (result_next),
    .in_ready  (buf_ready),
    .out_valid (results.valid),
    .out_data  (results.data),
    .out_ready (results.ready)
  );

  a_hold_no_step: assert property (@(posedge clk) disable iff (rst)
    accept && step_next == STEP_NONE |=> count == $past(count))
    else $error("count moved without a step");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    accept && step_next == STEP_CW |=> count == $past(count) + COUNT_WIDTH'(1))
    else $error("count did not advance on a clockwise step");

  a_step_needs_edge: assert property (@(posedge clk) disable iff (rst)
    accept && step_next != STEP_NONE |-> level_a != level_a_next)
    else $error("step without an edge on A");

  a_x1_ignores_fall: assert property (@(posedge clk) disable iff (rst)
    accept && level_a && !level_a_next && steps_per_click != STEPS_X2
    |-> step_next == STEP_NONE)
    else $error("falling edge counted in single-edge mode");

endmodule
